### rtl/core/cea_pkg.sv
// ----------------------------------------------------------------------------
// cea_pkg
// Shared types, codes and saturation helpers for the complex element ALU.
// ----------------------------------------------------------------------------
`default_nettype none

package cea_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int DW            = 32;       // data part width
    localparam int PW            = 2 * DW;   // product width
    localparam int RW            = PW + DW;  // divider remainder width
    localparam int QB            = DW;       // quotient bits computed

    typedef enum logic [2:0] {
        FN_ADD    = 3'd0,
        FN_SUB    = 3'd1,
        FN_MUL    = 3'd2,
        FN_DIV    = 3'd3,
        FN_ADD_RE = 3'd4,
        FN_SUB_RE = 3'd5,
        FN_MUL_RE = 3'd6,
        FN_DIV_RE = 3'd7
    } t_func;

    typedef struct packed {
        logic [DW-1:0] val;
        logic          ovf;
    } t_sat;

    // payload that rides along the divider stages
    typedef struct packed {
        logic          is_div;
        logic          dz;
        logic          last;
        logic [DW-1:0] re;
        logic [DW-1:0] im;
        logic          ovf;
    } t_carry;

    // saturate a signed wide value to 32 bits
    function automatic t_sat sat_wide(input logic signed [PW+1:0] v);
        t_sat r;
        if (v > $signed({{(PW-DW+3){1'b0}}, {(DW-1){1'b1}}})) begin
            r.val = {1'b0, {(DW-1){1'b1}}};
            r.ovf = 1'b1;
        end else if (v < $signed({{(PW-DW+3){1'b1}}, {(DW-1){1'b0}}})) begin
            r.val = {1'b1, {(DW-1){1'b0}}};
            r.ovf = 1'b1;
        end else begin
            r.val = v[DW-1:0];
            r.ovf = 1'b0;
        end
        return r;
    endfunction

    // saturate a quotient magnitude with sign; big marks q >= 2^32
    function automatic t_sat sat_div(input logic [DW-1:0] q, input logic neg,
                                     input logic big);
        t_sat r;
        if (!neg) begin
            if (big || q[DW-1]) begin
                r.val = {1'b0, {(DW-1){1'b1}}};
                r.ovf = 1'b1;
            end else begin
                r.val = q;
                r.ovf = 1'b0;
            end
        end else begin
            if (big || (q[DW-1] && (q[DW-2:0] != '0))) begin
                r.val = {1'b1, {(DW-1){1'b0}}};
                r.ovf = 1'b1;
            end else begin
                r.val = DW'(-q);
                r.ovf = 1'b0;
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

### rtl/core/complex_element_alu_top.sv
// ----------------------------------------------------------------------------
// complex_element_alu_top
// Pipelined element-wise complex add/sub/mul/div on Q(32-F).F values.
// ----------------------------------------------------------------------------
//  channel | dir | tdata                         | tuser             | tlast
//  s       | in  | a_re, a_im, b_re, b_im (128b) | func [2:0]        | last_element
//  m       | out | res_re, res_im (64b)          | overflow, div0    | last_result
//
//  One item can be accepted every cycle while the pipe is not stalled.
//  Depth is set by the restoring divider: one quotient bit per stage, 32 stages.
//  Stage 1 holds the six 32x32 products, stage 2 the sums and non-divide
//  results, stage 3 the quotient range check, then 32 divider stages and
//  the output register.
//  A stall (result waiting, m tready low) freezes the whole pipe; s tready
//  drops with it. Reset clears only the valid bits.
`default_nettype none

module complex_element_alu_top #(
    parameter int FRAC_BITS = cea_pkg::FRAC_BITS_DEF
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_s_tvalid,
    output logic              o_s_tready,
    input  wire logic [127:0] i_s_tdata,   // a_re, a_im, b_re, b_im (low to high)
    input  wire logic [2:0]   i_s_tuser,   // func
    input  wire logic         i_s_tlast,   // last_element
    output logic              o_m_tvalid,
    input  wire logic         i_m_tready,
    output logic [63:0]       o_m_tdata,   // res_re, res_im (low to high)
    output logic [1:0]        o_m_tuser,   // overflow, divide_by_zero (low to high)
    output logic              o_m_tlast    // last_result
);
    import cea_pkg::*;

    localparam int NS = 3 + QB + 1;   // valid bits: s1, s2, check, divider, out

    logic          en;
    logic [NS-1:0] r_vld;

    // pipe advances whenever the output register is free or being taken
    assign en         = !r_vld[NS-1] || i_m_tready;
    assign o_s_tready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[NS-2:0], i_s_tvalid};
        end
    end

    // ---------------- stage 1: operands and products ----------------
    t_func                 r1_func;
    logic                  r1_last;
    logic signed [DW-1:0]  r1_ar, r1_ai, r1_br, r1_bi;
    logic signed [PW-1:0]  r1_p_rr, r1_p_ii, r1_p_ir, r1_p_ri, r1_p_bb, r1_p_qq;
    logic signed [DW-1:0]  in_ar, in_ai, in_br, in_bi;

    assign in_ar = i_s_tdata[31:0];
    assign in_ai = i_s_tdata[63:32];
    assign in_br = i_s_tdata[95:64];
    assign in_bi = i_s_tdata[127:96];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_func <= t_func'(i_s_tuser);
            r1_last <= i_s_tlast;
            r1_ar   <= in_ar;
            r1_ai   <= in_ai;
            r1_br   <= in_br;
            r1_bi   <= in_bi;
            r1_p_rr <= PW'(in_ar) * PW'(in_br);
            r1_p_ii <= PW'(in_ai) * PW'(in_bi);
            r1_p_ir <= PW'(in_ai) * PW'(in_br);
            r1_p_ri <= PW'(in_ar) * PW'(in_bi);
            r1_p_bb <= PW'(in_br) * PW'(in_br);
            r1_p_qq <= PW'(in_bi) * PW'(in_bi);
        end
    end

    // ---------------- stage 2: sums, non-divide results, divide setup -------
    logic signed [PW+1:0] w_rr, w_ii, w_ir, w_ri, w_ar, w_ai, w_br, w_bi;
    logic signed [PW+1:0] s_re, s_im, nr_c, ni_c;
    t_sat                 sat_re, sat_im;
    t_carry               n2_cy, r2_cy;
    logic [PW-1:0]        n2_mag_re, n2_mag_im, n2_den;
    logic                 n2_neg_re, n2_neg_im;
    logic [PW-1:0]        r2_mag_re, r2_mag_im, r2_den;
    logic                 r2_neg_re, r2_neg_im;

    assign w_rr = (PW+2)'(r1_p_rr);
    assign w_ii = (PW+2)'(r1_p_ii);
    assign w_ir = (PW+2)'(r1_p_ir);
    assign w_ri = (PW+2)'(r1_p_ri);
    assign w_ar = {{(PW-DW+2){r1_ar[DW-1]}}, r1_ar};
    assign w_ai = {{(PW-DW+2){r1_ai[DW-1]}}, r1_ai};
    assign w_br = {{(PW-DW+2){r1_br[DW-1]}}, r1_br};
    assign w_bi = {{(PW-DW+2){r1_bi[DW-1]}}, r1_bi};
    assign nr_c = w_rr + w_ii;
    assign ni_c = w_ir - w_ri;

    always_comb begin
        s_re = '0;
        s_im = '0;
        case (r1_func)
            FN_ADD:    begin s_re = w_ar + w_br; s_im = w_ai + w_bi; end
            FN_SUB:    begin s_re = w_ar - w_br; s_im = w_ai - w_bi; end
            FN_MUL:    begin
                s_re = (w_rr - w_ii) >>> FRAC_BITS;
                s_im = (w_ir + w_ri) >>> FRAC_BITS;
            end
            FN_ADD_RE: begin s_re = w_ar + w_br; s_im = w_ai; end
            FN_SUB_RE: begin s_re = w_ar - w_br; s_im = w_ai; end
            FN_MUL_RE: begin
                s_re = w_rr >>> FRAC_BITS;
                s_im = w_ir >>> FRAC_BITS;
            end
            default:   begin s_re = '0; s_im = '0; end
        endcase
        sat_re = sat_wide(s_re);
        sat_im = sat_wide(s_im);

        n2_cy.is_div = (r1_func == FN_DIV) || (r1_func == FN_DIV_RE);
        n2_cy.last   = r1_last;
        n2_cy.re     = sat_re.val;
        n2_cy.im     = sat_im.val;
        n2_cy.ovf    = sat_re.ovf | sat_im.ovf;

        if (r1_func == FN_DIV) begin
            n2_den    = PW'(r1_p_bb) + PW'(r1_p_qq);
            n2_neg_re = nr_c[PW+1];
            n2_neg_im = ni_c[PW+1];
            n2_mag_re = nr_c[PW+1] ? PW'(-nr_c) : PW'(nr_c);
            n2_mag_im = ni_c[PW+1] ? PW'(-ni_c) : PW'(ni_c);
        end else begin
            n2_den    = r1_br[DW-1] ? PW'(-w_br) : PW'(w_br);
            n2_neg_re = r1_ar[DW-1] ^ r1_br[DW-1];
            n2_neg_im = r1_ai[DW-1] ^ r1_br[DW-1];
            n2_mag_re = r1_ar[DW-1] ? PW'(-w_ar) : PW'(w_ar);
            n2_mag_im = r1_ai[DW-1] ? PW'(-w_ai) : PW'(w_ai);
        end
        n2_cy.dz = n2_cy.is_div && (n2_den == '0);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_cy     <= n2_cy;
            r2_mag_re <= n2_mag_re;
            r2_mag_im <= n2_mag_im;
            r2_neg_re <= n2_neg_re;
            r2_neg_im <= n2_neg_im;
            r2_den    <= n2_den;
        end
    end

    // ---------------- stage 3 and divider stages ----------------
    // r_rem[j] etc. hold the state after j quotient bits
    logic [RW-1:0] r_rem_re [QB+1];
    logic [RW-1:0] r_rem_im [QB+1];
    logic [DW-1:0] r_q_re   [QB+1];
    logic [DW-1:0] r_q_im   [QB+1];
    logic [PW-1:0] r_den    [QB+1];
    logic          r_neg_re [QB+1];
    logic          r_neg_im [QB+1];
    logic          r_big_re [QB+1];
    logic          r_big_im [QB+1];
    t_carry        r_cy     [QB+1];

    logic [RW-1:0] x_re, x_im, d_top;

    assign x_re  = RW'(r2_mag_re) << FRAC_BITS;
    assign x_im  = RW'(r2_mag_im) << FRAC_BITS;
    assign d_top = RW'(r2_den) << QB;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_rem_re[0] <= x_re;
            r_rem_im[0] <= x_im;
            r_q_re[0]   <= '0;
            r_q_im[0]   <= '0;
            r_den[0]    <= r2_den;
            r_neg_re[0] <= r2_neg_re;
            r_neg_im[0] <= r2_neg_im;
            r_big_re[0] <= (x_re >= d_top);
            r_big_im[0] <= (x_im >= d_top);
            r_cy[0]     <= r2_cy;
        end
    end

    // one restoring step per stage, quotient bit QB-j
    for (genvar j = 1; j <= QB; j++) begin : g_div
        logic [RW-1:0] dk;
        logic          ge_re, ge_im;

        assign dk    = RW'(r_den[j-1]) << (QB - j);
        assign ge_re = r_rem_re[j-1] >= dk;
        assign ge_im = r_rem_im[j-1] >= dk;

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_rem_re[j] <= ge_re ? r_rem_re[j-1] - dk : r_rem_re[j-1];
                r_rem_im[j] <= ge_im ? r_rem_im[j-1] - dk : r_rem_im[j-1];
                r_q_re[j]   <= r_q_re[j-1] | (DW'(ge_re) << (QB - j));
                r_q_im[j]   <= r_q_im[j-1] | (DW'(ge_im) << (QB - j));
                r_den[j]    <= r_den[j-1];
                r_neg_re[j] <= r_neg_re[j-1];
                r_neg_im[j] <= r_neg_im[j-1];
                r_big_re[j] <= r_big_re[j-1];
                r_big_im[j] <= r_big_im[j-1];
                r_cy[j]     <= r_cy[j-1];
            end
        end
    end

    // ---------------- output register ----------------
    t_sat          dq_re, dq_im;
    logic [DW-1:0] n_out_re, n_out_im;
    logic          n_out_ovf;
    logic [DW-1:0] r_out_re, r_out_im;
    logic          r_out_ovf, r_out_dz, r_out_last;

    always_comb begin
        dq_re = sat_div(r_q_re[QB], r_neg_re[QB], r_big_re[QB]);
        dq_im = sat_div(r_q_im[QB], r_neg_im[QB], r_big_im[QB]);
        if (!r_cy[QB].is_div) begin
            n_out_re  = r_cy[QB].re;
            n_out_im  = r_cy[QB].im;
            n_out_ovf = r_cy[QB].ovf;
        end else if (r_cy[QB].dz) begin
            n_out_re  = '0;
            n_out_im  = '0;
            n_out_ovf = 1'b0;
        end else begin
            n_out_re  = dq_re.val;
            n_out_im  = dq_im.val;
            n_out_ovf = dq_re.ovf | dq_im.ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_re   <= n_out_re;
            r_out_im   <= n_out_im;
            r_out_ovf  <= n_out_ovf;
            r_out_dz   <= r_cy[QB].dz;
            r_out_last <= r_cy[QB].last;
        end
    end

    assign o_m_tvalid = r_vld[NS-1];
    assign o_m_tdata  = {r_out_im, r_out_re};
    assign o_m_tuser  = {r_out_dz, r_out_ovf};
    assign o_m_tlast  = r_out_last;

    // ---------------- assertions ----------------
    a_dz_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser[1]) |-> (o_m_tdata == '0 && !o_m_tuser[0]))
        else $error("divide by zero result not cleared");

    a_ovf_rail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser[0]) |->
            (o_m_tdata[31:0] == 32'h7fffffff || o_m_tdata[31:0] == 32'h80000000 ||
             o_m_tdata[63:32] == 32'h7fffffff || o_m_tdata[63:32] == 32'h80000000))
        else $error("overflow flag without a saturated part");

    a_dz_div_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[2] && r_cy[0].dz) |-> r_cy[0].is_div)
        else $error("divide flag on a non-divide item");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!en) |=> ($stable(r_vld) && $stable(r_q_re[QB])))
        else $error("pipe moved during a stall");

endmodule

`default_nettype wire
